>>> design/ssd_pkg.sv
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types and constants for the search stack with delete.
// ----------------------------------------------------------------------------
package ssd_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_FIND   = 2'd1,
        FUNC_DELETE = 2'd2,
        FUNC_DUMP   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_LOAD,
        S_PROP,
        S_APPLY,
        S_DUMP
    } t_state;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic push;   // shift toward tail, cell 0 takes the key
        logic rot;    // rotate toward tail, cell 0 takes the tail cell
        logic load;   // compare against key, clear prefix
        logic prop;   // ripple match prefix one cell further
        logic del;    // cells at or past the first match take their right neighbor
    } t_cell_ctl;

endpackage

>>> design/ssd_cell.sv
// ----------------------------------------------------------------------------
// ssd_cell
// One slot of the stack: holds a value, its match flag and the running
// match prefix from the head, and trades data with its two neighbors.
// ----------------------------------------------------------------------------
module ssd_cell #(
    parameter int DATA_WIDTH = ssd_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  ssd_pkg::t_cell_ctl    i_ctl,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic                  i_occ,
    input  logic [DATA_WIDTH-1:0] i_prev_data,
    input  logic [DATA_WIDTH-1:0] i_next_data,
    input  logic                  i_prev_pre,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic                  o_pre
);
    import ssd_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_hit;
    logic                  r_pre;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push || i_ctl.rot) begin
            r_data <= i_prev_data;
        end else if (i_ctl.del && r_pre) begin
            r_data <= i_next_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
            r_pre <= 1'b0;
        end else if (i_ctl.load) begin
            r_hit <= i_occ && (r_data == i_key);
            r_pre <= 1'b0;
        end else if (i_ctl.prop) begin
            // inclusive prefix: some cell from the head up to here matched
            r_pre <= r_hit || i_prev_pre;
        end
    end

    assign o_data = r_data;
    assign o_pre  = r_pre;

endmodule

>>> design/search_stack_with_delete_top.sv
// ----------------------------------------------------------------------------
// search_stack_with_delete_top
// Bounded stack of signed values with insert, find, delete-by-value and dump.
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH cells, newest at cell 0. An item is taken
// when start is high and busy is low; busy stays high until the final result
// has been registered. In find and delete the match prefix ripples one cell
// per cycle down the row, and a delete closes the gap in a single shift. In a
// dump the row rotates once around, and the tail cell supplies one entry per
// cycle, oldest first. Results come one beat per cycle on o_valid and cannot be
// held off; o_last marks the final beat of an item.
// ----------------------------------------------------------------------------
module search_stack_with_delete_top #(
    parameter int DEPTH      = ssd_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ssd_pkg::DATA_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_func,
    input  logic [DATA_WIDTH-1:0] i_value,
    output logic                  o_valid,
    output logic [1:0]            o_status,
    output logic [DATA_WIDTH-1:0] o_item,
    output logic                  o_last
);
    import ssd_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = $clog2(DEPTH);
    localparam logic [CW-1:0] FULL_C   = CW'(DEPTH);
    localparam logic [KW-1:0] STEP_END = KW'(DEPTH - 1);

    t_state                r_state, n_state;
    t_func                 r_func;
    logic [DATA_WIDTH-1:0] r_key;
    logic [CW-1:0]         r_count, n_count;
    logic [KW-1:0]         r_step, n_step;
    logic                  r_valid, n_valid;
    t_status               r_status, n_status;
    logic [DATA_WIDTH-1:0] r_item, n_item;
    logic                  r_last, n_last;
    t_cell_ctl             w_ctl;

    logic [DATA_WIDTH-1:0] w_data [DEPTH];
    logic                  w_pre  [DEPTH];
    logic [CW-1:0]         w_skip;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_prev_data;
            logic [DATA_WIDTH-1:0] w_next_data;
            logic                  w_prev_pre;
            logic                  w_occ;

            if (g == 0) begin : g_head
                assign w_prev_data = w_ctl.rot ? w_data[DEPTH-1] : r_key;
                assign w_prev_pre  = 1'b0;
            end else begin : g_body
                assign w_prev_data = w_data[g-1];
                assign w_prev_pre  = w_pre[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign w_next_data = w_data[g];
            end else begin : g_inner
                assign w_next_data = w_data[g+1];
            end

            assign w_occ = CW'(g) < r_count;

            ssd_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (w_ctl),
                .i_key      (r_key),
                .i_occ      (w_occ),
                .i_prev_data(w_prev_data),
                .i_next_data(w_next_data),
                .i_prev_pre (w_prev_pre),
                .o_data     (w_data[g]),
                .o_pre      (w_pre[g])
            );
        end
    endgenerate

    // rotation steps before the oldest entry reaches the tail cell
    assign w_skip = FULL_C - r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_step  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_step  <= n_step;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_item   <= n_item;
        r_last   <= n_last;
        if (start && !busy) begin
            r_func <= t_func'(i_func);
            r_key  <= i_value;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_step   = r_step;
        n_valid  = 1'b0;
        n_status = r_status;
        n_item   = r_item;
        n_last   = r_last;
        w_ctl    = '0;

        unique case (r_state)
            S_IDLE: begin
                n_step = '0;
                if (start) begin
                    unique case (t_func'(i_func))
                        FUNC_INSERT: n_state = S_INSERT;
                        FUNC_DUMP:   n_state = S_DUMP;
                        default:     n_state = S_LOAD;
                    endcase
                end
            end
            S_INSERT: begin
                n_valid = 1'b1;
                n_item  = r_key;
                n_last  = 1'b1;
                if (r_count == FULL_C) begin
                    n_status = ST_FULL;
                end else begin
                    w_ctl.push = 1'b1;
                    n_count    = r_count + 1'b1;
                    n_status   = ST_OK;
                end
                n_state = S_IDLE;
            end
            S_LOAD: begin
                w_ctl.load = 1'b1;
                n_step     = '0;
                n_state    = S_PROP;
            end
            S_PROP: begin
                w_ctl.prop = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_END) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_valid = 1'b1;
                n_item  = r_key;
                n_last  = 1'b1;
                if (w_pre[DEPTH-1]) begin
                    n_status = ST_OK;
                    if (r_func == FUNC_DELETE) begin
                        w_ctl.del = 1'b1;
                        n_count   = r_count - 1'b1;
                    end
                end else begin
                    n_status = ST_NOTFOUND;
                end
                n_state = S_IDLE;
            end
            S_DUMP: begin
                if (r_count == '0) begin
                    n_valid  = 1'b1;
                    n_status = ST_EMPTY;
                    n_item   = '0;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end else begin
                    w_ctl.rot = 1'b1;
                    n_step    = r_step + 1'b1;
                    if (CW'(r_step) >= w_skip) begin
                        n_valid  = 1'b1;
                        n_status = ST_OK;
                        n_item   = w_data[DEPTH-1];
                        n_last   = (r_step == STEP_END);
                    end
                    if (r_step == STEP_END) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_status = r_status;
    assign o_item   = r_item;
    assign o_last   = r_last;

endmodule

>>> design/ssd_checker.sv
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks on the search stack: result framing against busy.
// ----------------------------------------------------------------------------
module ssd_checker #(
    parameter int DATA_WIDTH = ssd_pkg::DATA_WIDTH_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  o_valid,
    input logic [1:0]            o_status,
    input logic [DATA_WIDTH-1:0] o_item,
    input logic                  o_last
);
    import ssd_pkg::*;

    // no beat follows a reset cycle
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // final beat of an item coincides with the block going free
    a_last_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy)
        else $error("busy still high on final beat");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> busy)
        else $error("block went free before final beat");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_last && o_item == '0)
        else $error("empty dump beat malformed");

endmodule

bind search_stack_with_delete_top ssd_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_ssd_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_valid (o_valid),
    .o_status(o_status),
    .o_item  (o_item),
    .o_last  (o_last)
);

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the search stack: a directed table covers the empty,
// extreme, duplicate and head-delete cases, and a fill run the full case. A long
// random run with many hitting keys then keeps every beat checked against a
// behavioral stack model.
// ----------------------------------------------------------------------------
module tb;
    import ssd_pkg::*;

    localparam int STACK_DEPTH = DEPTH_DEF;
    localparam int DW          = DATA_WIDTH_DEF;
    localparam int N_RANDOM    = 480;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PRINT_CAP   = 50;

    typedef struct packed {
        t_status         status;
        logic [DW-1:0]   item;
        logic            last;
    } t_reply;

    typedef struct packed {
        t_func           op;
        logic [DW-1:0]   val;
        logic            typed;
        t_status         want;
        logic [DW-1:0]   want_item;
    } t_cmd_row;

    logic          i_clk;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic          busy;
    logic [1:0]    i_func  = FUNC_INSERT;
    logic [DW-1:0] i_value = '0;
    logic          o_valid;
    logic [1:0]    o_status;
    logic [DW-1:0] o_item;
    logic          o_last;

    // behavioral copy of the list, slot 0 oldest
    logic [DW-1:0] model_mem [STACK_DEPTH];
    int            model_count = 0;
    t_reply        due_replies [$];

    int cycles    = 0;
    int n_errors  = 0;
    int n_items   = 0;
    int n_replies = 0;
    int n_full    = 0;
    int n_found   = 0;
    int n_del_hit = 0;
    int n_dump    = 0;

    search_stack_with_delete_top #(
        .DEPTH      (STACK_DEPTH),
        .DATA_WIDTH (DW)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_func   (i_func),
        .i_value  (i_value),
        .o_valid  (o_valid),
        .o_status (o_status),
        .o_item   (o_item),
        .o_last   (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, due_replies.size());
            $display("search_stack_with_delete_top regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                   input logic [DW-1:0] want);
        if (n_errors < PRINT_CAP)
            $display("mismatch @%0d: %s got %h want %h", cycles, what, got, want);
        n_errors++;
    endtask

    function automatic void add_reply(input t_status s, input logic [DW-1:0] v,
                                      input logic l);
        due_replies.push_back('{status: s, item: v, last: l});
    endfunction

    function automatic void predict_stack_op(input t_func op, input logic [DW-1:0] val);
        int hit;
        hit = -1;
        // last match in age order is the one nearest the head
        for (int i = 0; i < model_count; i++)
            if (model_mem[i] == val) hit = i;
        case (op)
            FUNC_INSERT: begin
                if (model_count == STACK_DEPTH) begin
                    add_reply(ST_FULL, val, 1'b1);
                    n_full++;
                end else begin
                    model_mem[model_count] = val;
                    model_count++;
                    add_reply(ST_OK, val, 1'b1);
                end
            end
            FUNC_FIND: begin
                if (hit >= 0) n_found++;
                add_reply(hit >= 0 ? ST_OK : ST_NOTFOUND, val, 1'b1);
            end
            FUNC_DELETE: begin
                if (hit < 0) begin
                    add_reply(ST_NOTFOUND, val, 1'b1);
                end else begin
                    for (int i = hit; i + 1 < model_count; i++)
                        model_mem[i] = model_mem[i + 1];
                    model_count--;
                    n_del_hit++;
                    add_reply(ST_OK, val, 1'b1);
                end
            end
            default: begin
                n_dump++;
                if (model_count == 0)
                    add_reply(ST_EMPTY, '0, 1'b1);
                for (int i = 0; i < model_count; i++)
                    add_reply(ST_OK, model_mem[i], i + 1 == model_count);
            end
        endcase
    endfunction

    function automatic int pick_gap(input int n);
        int r;
        r = $urandom_range(99);
        if ((n / 40) % 4 == 3) return 0;   // back-to-back stretch
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // stay idle for the given gap, then hold start until the block takes the beat
    task automatic send_cmd(input t_func op, input logic [DW-1:0] val, input int gap);
        repeat (gap) begin
            start   <= 1'b0;
            i_func  <= t_func'($urandom_range(3));
            i_value <= $urandom;
            @(posedge i_clk);
        end
        start   <= 1'b1;
        i_func  <= op;
        i_value <= val;
        do @(posedge i_clk); while (busy !== 1'b0);
        n_items++;
        predict_stack_op(op, val);
    endtask

    always @(posedge i_clk) begin : result_check
        t_reply want;
        if (i_rst_n && o_valid) begin
            if (due_replies.size() == 0) begin
                report_mismatch("unexpected result beat, item", o_item, '0);
            end else begin
                want = due_replies.pop_front();
                n_replies++;
                if (o_status !== want.status)
                    report_mismatch("status", DW'(o_status), DW'(want.status));
                if (o_item !== want.item)
                    report_mismatch("item", o_item, want.item);
                if (o_last !== want.last)
                    report_mismatch("last", DW'(o_last), DW'(want.last));
            end
        end
    end

    t_cmd_row dir_rows [18] = '{
        '{FUNC_DUMP,   32'h0000_0000, 1'b1, ST_EMPTY,    32'h0000_0000},
        '{FUNC_FIND,   32'h0000_0000, 1'b1, ST_NOTFOUND, 32'h0000_0000},
        '{FUNC_DELETE, 32'h8000_0000, 1'b1, ST_NOTFOUND, 32'h8000_0000},
        '{FUNC_INSERT, 32'h8000_0000, 1'b0, ST_OK,       32'h0},
        '{FUNC_INSERT, 32'h7fff_ffff, 1'b0, ST_OK,       32'h0},
        '{FUNC_INSERT, 32'hffff_ffff, 1'b0, ST_OK,       32'h0},
        '{FUNC_INSERT, 32'h0000_0000, 1'b0, ST_OK,       32'h0},
        '{FUNC_INSERT, 32'h7fff_ffff, 1'b0, ST_OK,       32'h0},
        '{FUNC_FIND,   32'h8000_0000, 1'b0, ST_OK,       32'h0},
        '{FUNC_FIND,   32'h7fff_fffe, 1'b0, ST_OK,       32'h0},
        '{FUNC_FIND,   32'hffff_ffff, 1'b0, ST_OK,       32'h0},
        '{FUNC_DUMP,   32'h0000_0000, 1'b0, ST_OK,       32'h0},
        '{FUNC_DELETE, 32'h7fff_ffff, 1'b0, ST_OK,       32'h0},
        '{FUNC_DUMP,   32'h0000_0000, 1'b0, ST_OK,       32'h0},
        '{FUNC_DELETE, 32'h8000_0000, 1'b0, ST_OK,       32'h0},
        '{FUNC_DELETE, 32'h1234_5678, 1'b0, ST_OK,       32'h0},
        '{FUNC_DELETE, 32'h0000_0000, 1'b0, ST_OK,       32'h0},
        '{FUNC_DUMP,   32'hdead_beef, 1'b0, ST_OK,       32'h0}
    };

    initial begin
        logic [DW-1:0] val;
        t_func         op;
        int            r;
        int            ins_w;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            send_cmd(dir_rows[k].op, dir_rows[k].val, pick_gap(k));
            if (dir_rows[k].typed) begin
                void'(due_replies.pop_back());
                add_reply(dir_rows[k].want, dir_rows[k].want_item, 1'b1);
            end
        end

        // fill to capacity, push once more and read it all back, then delete the newest and dump again
        while (model_count < STACK_DEPTH)
            send_cmd(FUNC_INSERT, $urandom, pick_gap(0));
        val = $urandom;
        send_cmd(FUNC_INSERT, val, 0);
        void'(due_replies.pop_back());
        add_reply(ST_FULL, val, 1'b1);
        send_cmd(FUNC_DUMP, '0, pick_gap(0));
        send_cmd(FUNC_DELETE, model_mem[STACK_DEPTH - 1], 0);
        send_cmd(FUNC_DUMP, '1, 0);

        start <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);

        for (int n = 0; n < N_RANDOM; n++) begin
            // key: often one already stored, some small shared values, rest wide
            r = $urandom_range(99);
            if (r < 45 && model_count > 0)
                val = model_mem[$urandom_range(model_count - 1)];
            else if (r < 70)
                val = DW'($urandom_range(7)) - DW'(4);
            else if (r < 75)
                val = r[0] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            else
                val = $urandom;

            // alternate fill-heavy and drain-heavy phases
            ins_w = ((n / 60) % 2 == 0) ? 50 : 20;
            r = $urandom_range(99);
            if (r < ins_w)                      op = FUNC_INSERT;
            else if (r < ins_w + (88 - ins_w) / 2) op = FUNC_FIND;
            else if (r < 88)                    op = FUNC_DELETE;
            else                                op = FUNC_DUMP;

            send_cmd(op, val, pick_gap(n));

            if (n == N_RANDOM / 2) begin
                start <= 1'b0;
                while (due_replies.size() != 0) @(posedge i_clk);
            end
        end

        start <= 1'b0;
        while (due_replies.size() != 0) @(posedge i_clk);
        repeat (STACK_DEPTH + 8) @(posedge i_clk);

        $display("ran %0d commands, checked %0d result beats", n_items, n_replies);
        $display("dumps %0d, finds hit %0d, deletes hit %0d, inserts refused as full %0d",
                 n_dump, n_found, n_del_hit, n_full);
        if (n_errors == 0) begin
            $display("search_stack_with_delete_top regression: pass");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("search_stack_with_delete_top regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
design/ssd_pkg.sv
design/ssd_cell.sv
design/search_stack_with_delete_top.sv
design/ssd_checker.sv
dv/tb.sv
